@@ design/erl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erl_pkg
// Shared types and constants for the enclosing region lookup block.
// ----------------------------------------------------------------------------
package erl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  // Slot field is 6 bits, so no more than this many slots are ever written
  localparam int MAX_SLOTS         = 64;
  localparam int SLOT_W            = 6;
  localparam int SLOT_CMP_W        = SLOT_W + 1;
  localparam int ADDR_W            = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] entry_index;
    logic [ADDR_W-1:0] entry_base;
    logic [ADDR_W-1:0] entry_size;
    logic              entry_eligible;
    logic [ADDR_W-1:0] query_address;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] region_index;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;   // store the accepted write request
    logic start;   // latch query, clear search state
    logic scan;    // read one table slot, advance counter
    logic finish;  // resolve bound, load response register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // counter sits on the last slot
    logic rsp_busy;   // response register full and not taken this cycle
  } sts_t;

endpackage

@@ design/erl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module erl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/erl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erl_ctrl
// Sequencer: accepts requests, walks the table scan, hands off the response.
// ----------------------------------------------------------------------------
module erl_ctrl
  import erl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_op,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_op == OP_QUERY) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last slot's read data is compared here
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.rsp_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/erl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erl_dp
// Datapath: region table, valid bits, scan compare and response register.
// ----------------------------------------------------------------------------
module erl_dp
  import erl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req_data,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  // slots beyond the 6-bit index range can never be written, so never match
  localparam int SLOTS = (TABLE_ENTRIES < MAX_SLOTS) ? TABLE_ENTRIES : MAX_SLOTS;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [SLOTS-1:0] valid;
  logic             slot_ok;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;

  logic [IDX_W-1:0]    cnt;
  logic [2*ADDR_W-1:0] rd_word;
  logic                cmp_en;
  logic [IDX_W-1:0]    cmp_idx;
  logic                cmp_vld;
  logic [ADDR_W-1:0]   cur_base;
  logic [ADDR_W-1:0]   cur_len;

  logic [ADDR_W-1:0] query;
  logic              have;
  logic              have_next;
  logic [IDX_W-1:0]  best_idx;
  logic [ADDR_W-1:0] best_base;
  logic [ADDR_W-1:0] best_len;
  logic [ADDR_W-1:0] next_base;

  logic [ADDR_W-1:0] region_end;
  logic [ADDR_W-1:0] upper;
  logic              hit;

  assign slot_ok = ({1'b0, req_data.entry_index} < SLOT_CMP_W'(SLOTS));
  assign wr_en   = cmd.wr_en && slot_ok;
  assign wr_idx  = req_data.entry_index[IDX_W-1:0];

  // table word: base in the upper half, length in the lower half
  erl_ram #(
    .WIDTH (2 * ADDR_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata ({req_data.entry_base, req_data.entry_size}),
    .re    (cmd.scan),
    .raddr (cnt),
    .rdata (rd_word)
  );

  assign cur_base = rd_word[2*ADDR_W-1:ADDR_W];
  assign cur_len  = rd_word[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= req_data.entry_eligible;
    end
  end

  // scan counter and read-aligned side band
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.start) begin
        cnt <= '0;
      end else if (cmd.scan && cnt != LAST_IDX) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
    cmp_vld <= valid[cnt];
  end

  assign sts.scan_last = (cnt == LAST_IDX);
  assign sts.rsp_busy  = rsp_valid && !rsp_ready;

  // floor search and ceiling search, one slot a cycle; strict compares keep
  // the lowest index on equal bases
  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      have_next <= 1'b0;
    end else if (cmd.start) begin
      have      <= 1'b0;
      have_next <= 1'b0;
    end else if (cmp_en && cmp_vld) begin
      if (cur_base <= query) begin
        if (!have || cur_base > best_base) begin
          have <= 1'b1;
        end
      end else if (!have_next || cur_base < next_base) begin
        have_next <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      query <= req_data.query_address;
    end
    if (cmp_en && cmp_vld) begin
      if (cur_base <= query) begin
        if (!have || cur_base > best_base) begin
          best_idx  <= cmp_idx;
          best_base <= cur_base;
          best_len  <= cur_len;
        end
      end else if (!have_next || cur_base < next_base) begin
        next_base <= cur_base;
      end
    end
  end

  assign region_end = best_base + best_len;
  assign upper      = have_next ? next_base : {ADDR_W{1'b1}};

  always_comb begin
    hit = 1'b0;
    if (have) begin
      if (best_len != '0) begin
        hit = (query < region_end);
      end else begin
        hit = (query < upper);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_data.found        <= hit;
      rsp_data.region_index <= hit ? SLOT_W'(best_idx) : '0;
    end
  end

endmodule

@@ design/enclosing_region_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enclosing_region_lookup
// Region table with a scanning lookup of the region holding an address.
// ----------------------------------------------------------------------------
//  channel | ports                            | moves
//  --------+----------------------------------+-------------------------------
//  req     | req_valid, req_ready, req_data   | table write or address query
//  rsp     | rsp_valid, rsp_ready, rsp_data   | found flag and region slot
//
//  A write request completes on the accepting edge; no response.
//  A query scans all N = min(TABLE_ENTRIES, 64) table slots (64 by default):
//  the scan reads one table slot a cycle from the single RAM read port.
//  Reset clears all entry valid bits at once; no clearing pass.
//  The response sits in an output register; a new request is taken while it
//  waits, and a query finishing behind a stalled response holds until taken.
// ----------------------------------------------------------------------------
module enclosing_region_lookup
  import erl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  cmd_t cmd;
  sts_t sts;

  erl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req_data.op),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  erl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

@@ tb/sv/enclosing_region_lookup_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enclosing_region_lookup_test
// Self-checking bench for the region lookup. A mirror of the region table
// predicts every query response. Checks cover an empty table, boundary and
// tie cases, clustered random traffic, a long response stall and a stream
// with no gaps.
// ----------------------------------------------------------------------------
module enclosing_region_lookup_test;
  import erl_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int SLOTS        = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 600;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  // mirror of the block's region table
  logic [ADDR_W-1:0] mirror_base [SLOTS];
  logic [ADDR_W-1:0] mirror_len  [SLOTS];
  logic              mirror_elig [SLOTS];

  rsp_t        pending_regions[$];
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  logic        no_idle       = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_left    = 0;

  enclosing_region_lookup DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // greatest eligible base not above addr; bound by length or next base
  function automatic rsp_t lookup_region(input logic [ADDR_W-1:0] addr);
    rsp_t              res;
    int                best;
    logic              have;
    logic              have_next;
    logic [ADDR_W-1:0] best_base;
    logic [ADDR_W-1:0] next_base;
    logic [ADDR_W-1:0] bound;
    logic              hit;
    best      = 0;
    have      = 1'b0;
    have_next = 1'b0;
    best_base = '0;
    next_base = '0;
    hit       = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (mirror_elig[i]) begin
        if (mirror_base[i] <= addr) begin
          if (!have || mirror_base[i] > best_base) begin
            have      = 1'b1;
            best      = i;
            best_base = mirror_base[i];
          end
        end else if (!have_next || mirror_base[i] < next_base) begin
          have_next = 1'b1;
          next_base = mirror_base[i];
        end
      end
    end
    if (have) begin
      if (mirror_len[best] != '0) bound = best_base + mirror_len[best];
      else bound = have_next ? next_base : ALL_ONES;
      hit = addr < bound;
    end
    res.found        = hit;
    res.region_index = hit ? SLOT_W'(best) : '0;
    return res;
  endfunction

  // address at or around a stored base
  function automatic logic [ADDR_W-1:0] near_base_address();
    int unsigned s;
    s = $urandom_range(0, SLOTS - 1);
    case ($urandom_range(0, 9))
      6:       return mirror_base[s];
      7:       return mirror_base[s] - 1;
      8:       return rand_addr();
      9:       return ALL_ONES - $urandom_range(0, 3);
      default: return mirror_base[s] + $urandom_range(0, 4200);
    endcase
  endfunction

  task automatic send_request(input req_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (!req_ready);
    if (item.op == OP_WRITE) begin
      mirror_base[item.entry_index] = item.entry_base;
      mirror_len[item.entry_index]  = item.entry_size;
      mirror_elig[item.entry_index] = item.entry_eligible;
    end else begin
      pending_regions.insert(pending_regions.size(), lookup_region(item.query_address));
    end
  endtask

  task automatic write_region(input int unsigned slot, input logic [ADDR_W-1:0] base,
                              input logic [ADDR_W-1:0] size, input logic elig);
    req_t item;
    item.op             = OP_WRITE;
    item.entry_index    = SLOT_W'(slot);
    item.entry_base     = base;
    item.entry_size     = size;
    item.entry_eligible = elig;
    item.query_address  = rand_addr();  // ignored on a write
    send_request(item);
  endtask

  task automatic query_region(input logic [ADDR_W-1:0] addr);
    req_t item;
    // entry fields are don't-care on a query
    item.op             = OP_QUERY;
    item.entry_index    = SLOT_W'($urandom);
    item.entry_base     = rand_addr();
    item.entry_size     = rand_addr();
    item.entry_eligible = 1'($urandom);
    item.query_address  = addr;
    send_request(item);
  endtask

  task automatic test_empty_table();
    query_region('0);
    query_region(ALL_ONES);
    query_region(rand_addr());
  endtask

  task automatic test_directed();
    write_region(0, 64'h1000, 64'h100, 1'b1);
    query_region(64'h1000);
    query_region(64'h10FF);
    query_region(64'h1100);   // bound is excluded
    query_region(64'h0FFF);
    // equal bases: lower slot must win
    write_region(5, 64'h2000, 64'h10, 1'b1);
    write_region(3, 64'h2000, 64'h20, 1'b1);
    query_region(64'h2008);
    query_region(64'h201F);
    // zero length bounded by next eligible base; ineligible slot is skipped
    write_region(7, 64'h3000, '0, 1'b1);
    write_region(9, 64'h4000, ALL_ONES, 1'b0);
    write_region(8, 64'h5000, 64'h10, 1'b1);
    query_region(64'h4000);
    query_region(64'h4FFF);
    query_region(64'h5000);
    // zero length with nothing above: all-ones is never enclosed
    write_region(63, 64'hFFFF_FFFF_FFFF_0000, '0, 1'b1);
    query_region(ALL_ONES);
    query_region(ALL_ONES - 1);
    write_region(62, ALL_ONES, 64'h1, 1'b1);
    query_region(ALL_ONES);
    write_region(1, '0, ALL_ONES, 1'b1);
    query_region(64'h500);
    // base + length wraps below the address
    write_region(63, 64'hFFFF_FFFF_FFFF_FF00, ALL_ONES, 1'b1);
    query_region(64'hFFFF_FFFF_FFFF_FF80);
  endtask

  task automatic test_random_traffic(input int unsigned count, input logic [ADDR_W-1:0] window);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 99) < 85) base = {window[ADDR_W-1:16], 16'($urandom)};
        else base = rand_addr();
        case ($urandom_range(0, 9))
          0, 1, 2: size = '0;
          7:       size = rand_addr();
          8:       size = ALL_ONES - $urandom_range(0, 255);
          9:       size = ADDR_W'($urandom_range(4097, 65536));
          default: size = ADDR_W'($urandom_range(1, 4096));
        endcase
        write_region($urandom_range(0, SLOTS - 1), base, size, $urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 9) == 0) begin
        query_region({window[ADDR_W-1:16], 16'($urandom)});
      end else begin
        query_region(near_base_address());
      end
    end
  endtask

  // receiver stalls long enough for the block to back up into req_ready
  task automatic test_response_hold();
    no_idle       <= 1'b1;
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < 30; n++) query_region(near_base_address());
  endtask

  task automatic test_burst();
    for (int n = 0; n < 80; n++) begin
      if ($urandom_range(0, 3) == 0)
        write_region($urandom_range(0, SLOTS - 1), near_base_address(),
                     ADDR_W'($urandom_range(0, 2048)), 1'b1);
      else
        query_region(near_base_address());
    end
    no_idle <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready  <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_response
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_regions.size() == 0) begin
        $error("response with no query outstanding: found=%0b region_index=%0d",
               rsp_data.found, rsp_data.region_index);
        error_count++;
      end else begin
        want = pending_regions.pop_front();
        if (rsp_data.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, rsp_data.found);
          error_count++;
        end
        if (rsp_data.region_index !== want.region_index) begin
          $error("region_index: expected %0d, got %0d",
                 want.region_index, rsp_data.region_index);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mirror_base[i] = '0;
      mirror_len[i]  = '0;
      mirror_elig[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_directed();
    test_random_traffic(180, '0);
    test_response_hold();
    test_random_traffic(180, 64'hFFFF_FFFF_FFFF_0000);
    test_burst();
    test_random_traffic(180, rand_addr());
    test_random_traffic(180, rand_addr());

    req_valid <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
